>>> hdl/stg_pkg.sv
// shared types, constants and microcode of the sine tone generator
package stg_pkg;

    // field widths
    localparam int FREQ_W      = 16;
    localparam int DUR_W       = 16;
    localparam int RATE_W      = 17;
    localparam int VOL_W       = 15;
    localparam int LEFT_W      = 23;
    localparam int SAMPLE_W    = 16;
    localparam int SINE_W      = 15;
    localparam int PROD_W      = RATE_W + DUR_W;
    localparam int CFG_IDX_W   = 2;
    localparam int CFG_DATA_W  = RATE_W;

    // sine table geometry
    localparam int SINE_DEPTH  = 1024;
    localparam int SINE_ADDR_W = $clog2(SINE_DEPTH);
    localparam logic [SINE_W-1:0] SINE_PEAK = '1;
    localparam logic [63:0] HALF_PI_Q30 = 64'd1686629713;

    // defaults
    localparam int STG_PHASE_BITS = 32;
    localparam logic [RATE_W-1:0] RATE_RESET   = RATE_W'(16000);
    localparam logic [VOL_W-1:0]  VOLUME_RESET = VOL_W'(8000);

    // sample count divide by 1000: shift out a factor of 8, then multiply by ceil(2^35/125)
    localparam int MS_PRE_SHIFT   = 3;
    localparam int MS_RECIP_W     = 29;
    localparam int MS_RECIP_SHIFT = 35;
    localparam logic [MS_RECIP_W-1:0] MS_RECIP = 29'd274877907;
    localparam int MS_SCALED_W    = PROD_W - MS_PRE_SHIFT;
    localparam int MS_RPROD_W     = MS_SCALED_W + MS_RECIP_W;

    // request opcodes
    localparam logic OP_LOAD = 1'b0;
    localparam logic OP_TICK = 1'b1;

    // register indexes
    typedef enum logic [CFG_IDX_W-1:0] {
        REG_SAMPLE_RATE = 2'd0,
        REG_VOLUME      = 2'd1
    } t_cfg_reg;

    typedef struct packed {
        logic              op;
        logic [FREQ_W-1:0] freq_hz;
        logic [DUR_W-1:0]  length_ms;
        logic              silent;
    } t_in_item;

    typedef struct packed {
        logic signed [SAMPLE_W-1:0] sample;
        logic                       last;
    } t_out_item;

    // microprogram steps
    typedef enum logic [3:0] {
        UPC_IDLE,
        UPC_DISPATCH,
        UPC_TICK_CHK,
        UPC_TICK_RD,
        UPC_TICK_MUL,
        UPC_TICK_OUT,
        UPC_LD_MUL,
        UPC_LD_RECIP,
        UPC_LD_INIT_STEP,
        UPC_LD_DIV_STEP,
        UPC_LD_DONE
    } t_upc;

    // sequencing: next, goto, branch if cond, hold while cond then goto
    typedef enum logic [1:0] {
        SEQ_NEXT,
        SEQ_GOTO,
        SEQ_BR,
        SEQ_HOLD
    } t_seq_op;

    typedef enum logic [2:0] {
        COND_NEVER,
        COND_NO_REQ,
        COND_OP_LOAD,
        COND_LEFT_ZERO,
        COND_OUT_FULL,
        COND_DIV_MORE
    } t_cond;

    typedef enum logic [3:0] {
        DP_NOP,
        DP_TICK_RD,
        DP_MUL_VOL,
        DP_EMIT,
        DP_MUL_CNT,
        DP_MUL_RECIP,
        DP_DIV_STEP,
        DP_SET_CNT,
        DP_SET_STEP
    } t_dp_op;

    typedef struct packed {
        t_seq_op seq;
        t_cond   cond;
        t_upc    target;
        t_dp_op  dp;
        logic    in_ready;
    } t_uword;

    typedef struct packed {
        logic no_req;
        logic op_load;
        logic left_zero;
        logic out_full;
        logic div_more;
    } t_status;

    function automatic t_uword mk_uword(input t_seq_op seq, input t_cond cond,
                                        input t_upc target, input t_dp_op dp,
                                        input logic in_ready);
        t_uword w;
        w.seq      = seq;
        w.cond     = cond;
        w.target   = target;
        w.dp       = dp;
        w.in_ready = in_ready;
        return w;
    endfunction

    // control store
    function automatic t_uword ucode(input t_upc upc);
        t_uword w;
        w = mk_uword(SEQ_GOTO, COND_NEVER, UPC_IDLE, DP_NOP, 1'b0);
        unique case (upc)
            UPC_IDLE:         w = mk_uword(SEQ_HOLD, COND_NO_REQ, UPC_DISPATCH, DP_NOP, 1'b1);
            UPC_DISPATCH:     w = mk_uword(SEQ_BR, COND_OP_LOAD, UPC_LD_MUL, DP_NOP, 1'b0);
            UPC_TICK_CHK:     w = mk_uword(SEQ_BR, COND_LEFT_ZERO, UPC_IDLE, DP_NOP, 1'b0);
            UPC_TICK_RD:      w = mk_uword(SEQ_NEXT, COND_NEVER, UPC_IDLE, DP_TICK_RD, 1'b0);
            UPC_TICK_MUL:     w = mk_uword(SEQ_NEXT, COND_NEVER, UPC_IDLE, DP_MUL_VOL, 1'b0);
            UPC_TICK_OUT:     w = mk_uword(SEQ_HOLD, COND_OUT_FULL, UPC_IDLE, DP_EMIT, 1'b0);
            UPC_LD_MUL:       w = mk_uword(SEQ_NEXT, COND_NEVER, UPC_IDLE, DP_MUL_CNT, 1'b0);
            UPC_LD_RECIP:     w = mk_uword(SEQ_NEXT, COND_NEVER, UPC_IDLE, DP_MUL_RECIP, 1'b0);
            UPC_LD_INIT_STEP: w = mk_uword(SEQ_NEXT, COND_NEVER, UPC_IDLE, DP_SET_CNT, 1'b0);
            UPC_LD_DIV_STEP:  w = mk_uword(SEQ_HOLD, COND_DIV_MORE, UPC_LD_DONE,
                                           DP_DIV_STEP, 1'b0);
            UPC_LD_DONE:      w = mk_uword(SEQ_GOTO, COND_NEVER, UPC_IDLE, DP_SET_STEP, 1'b0);
            default: ;
        endcase
        return w;
    endfunction

    // quarter wave entry from angle x in q30, taylor series to x^11
    function automatic logic [SINE_W-1:0] sine_from_x(input logic [63:0] x);
        logic [63:0]        x2;
        logic [63:0]        t;
        logic signed [65:0] s;
        logic [63:0]        v;
        x2 = (x * x) >> 30;
        t  = x;
        s  = $signed({2'b00, x});
        t  = ((t * x2) >> 30) / 64'd6;
        s  = s - $signed({2'b00, t});
        t  = ((t * x2) >> 30) / 64'd20;
        s  = s + $signed({2'b00, t});
        t  = ((t * x2) >> 30) / 64'd42;
        s  = s - $signed({2'b00, t});
        t  = ((t * x2) >> 30) / 64'd72;
        s  = s + $signed({2'b00, t});
        t  = ((t * x2) >> 30) / 64'd110;
        s  = s - $signed({2'b00, t});
        if (s < 0) begin
            s = '0;
        end
        v = (s[63:0] * 64'd32767 + 64'd536870912) >> 30;
        if (v > 64'd32767) begin
            v = 64'd32767;
        end
        return v[SINE_W-1:0];
    endfunction

endpackage

>>> hdl/sine_tone_generator.sv
// sine tone generator top level: sequencer, datapath and sine table
// tick request: if samples are left, one table read and one multiply, then the sample goes to
//   the output register; the next request is taken after that, held while the output is full
// load request: ready again once the bit-serial divide for the phase step is done; the
//   sample count takes the shared multiply and then a reciprocal multiply
// reset: synchronous active low, sequencer to idle, registers to defaults, no sweep
module sine_tone_generator
    import stg_pkg::*;
#(
    parameter int PHASE_BITS = STG_PHASE_BITS
) (
    input  logic                  i_clk,
    input  logic                  i_rst_n,
    // request channel
    input  logic                  i_in_valid,
    output logic                  o_in_ready,
    input  t_in_item              i_in_data,
    // sample channel
    output logic                  o_out_valid,
    input  logic                  i_out_ready,
    output t_out_item             o_out_data,
    // register write channel
    input  logic                  i_cfg_valid,
    output logic                  o_cfg_ready,
    input  logic [CFG_IDX_W-1:0]  i_cfg_index,
    input  logic [CFG_DATA_W-1:0] i_cfg_data
);

    t_uword                 w_ctrl;
    t_status                w_status;
    logic                   w_rom_rd;
    logic [SINE_ADDR_W-1:0] w_rom_addr;
    logic [SINE_W-1:0]      w_rom_data;

    // requests are taken only in the idle step of the microprogram
    assign o_in_ready  = w_ctrl.in_ready;
    // register writes always land at once; the user must issue them only while idle, the block does not enforce this
    assign o_cfg_ready = 1'b1;

    // control store and step counter
    stg_useq u_useq (
        .i_clk    (i_clk),
        .i_rst_n  (i_rst_n),
        .i_status (w_status),
        .o_ctrl   (w_ctrl)
    );

    // datapath driven by one control word per step
    stg_dp #(
        .PHASE_BITS (PHASE_BITS)
    ) u_dp (
        .i_clk       (i_clk),
        .i_rst_n     (i_rst_n),
        .i_ctrl      (w_ctrl),
        .o_status    (w_status),
        .i_in_valid  (i_in_valid),
        .i_in_data   (i_in_data),
        .o_out_valid (o_out_valid),
        .i_out_ready (i_out_ready),
        .o_out_data  (o_out_data),
        .i_cfg_valid (i_cfg_valid),
        .i_cfg_index (i_cfg_index),
        .i_cfg_data  (i_cfg_data),
        .o_rom_rd    (w_rom_rd),
        .o_rom_addr  (w_rom_addr),
        .i_rom_data  (w_rom_data)
    );

    // quarter wave table, data valid in the cycle after the read step
    stg_sine_rom u_rom (
        .i_clk   (i_clk),
        .i_rd_en (w_rom_rd),
        .i_addr  (w_rom_addr),
        .o_data  (w_rom_data)
    );

endmodule

>>> hdl/stg_sine_rom.sv
// quarter wave sine table with registered read
module stg_sine_rom
    import stg_pkg::*;
(
    input  logic                   i_clk,
    input  logic                   i_rd_en,
    input  logic [SINE_ADDR_W-1:0] i_addr,
    output logic [SINE_W-1:0]      o_data
);

    logic [SINE_W-1:0] w_rom [SINE_DEPTH];
    logic [SINE_W-1:0] r_data;

    for (genvar k = 0; k < SINE_DEPTH; k++) begin : g_entry
        localparam logic [63:0] X = (HALF_PI_Q30 * 64'(k)) / SINE_DEPTH;
        localparam logic [SINE_W-1:0] V = sine_from_x(X);
        assign w_rom[k] = V;
    end

    always_ff @(posedge i_clk) begin
        if (i_rd_en) begin
            r_data <= w_rom[i_addr];
        end
    end

    assign o_data = r_data;

endmodule

>>> hdl/stg_useq.sv
// microprogram sequencer: step counter, control store and branch logic
module stg_useq
    import stg_pkg::*;
(
    input  logic    i_clk,
    input  logic    i_rst_n,
    input  t_status i_status,
    output t_uword  o_ctrl
);

    t_upc   r_upc;
    t_upc   n_upc;
    t_upc   w_upc_inc;
    t_uword w_word;
    logic   w_cond;

    assign w_word    = ucode(r_upc);
    assign w_upc_inc = t_upc'(r_upc + 4'd1);

    always_comb begin
        unique case (w_word.cond)
            COND_NEVER:     w_cond = 1'b0;
            COND_NO_REQ:    w_cond = i_status.no_req;
            COND_OP_LOAD:   w_cond = i_status.op_load;
            COND_LEFT_ZERO: w_cond = i_status.left_zero;
            COND_OUT_FULL:  w_cond = i_status.out_full;
            COND_DIV_MORE:  w_cond = i_status.div_more;
            default:        w_cond = 1'b0;
        endcase
    end

    always_comb begin
        unique case (w_word.seq)
            SEQ_NEXT: n_upc = w_upc_inc;
            SEQ_GOTO: n_upc = w_word.target;
            SEQ_BR:   n_upc = w_cond ? w_word.target : w_upc_inc;
            SEQ_HOLD: n_upc = w_cond ? r_upc : w_word.target;
            default:  n_upc = UPC_IDLE;
        endcase
    end

    always_comb begin
        o_ctrl = w_word;
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_upc <= UPC_IDLE;
        end else begin
            r_upc <= n_upc;
        end
    end

endmodule

>>> hdl/stg_dp.sv
// datapath: registers, shared multiplier, count scaler, serial divider, phase and output
module stg_dp
    import stg_pkg::*;
#(
    parameter int PHASE_BITS = STG_PHASE_BITS
) (
    input  logic                   i_clk,
    input  logic                   i_rst_n,
    input  t_uword                 i_ctrl,
    output t_status                o_status,
    input  logic                   i_in_valid,
    input  t_in_item               i_in_data,
    output logic                   o_out_valid,
    input  logic                   i_out_ready,
    output t_out_item              o_out_data,
    input  logic                   i_cfg_valid,
    input  logic [CFG_IDX_W-1:0]   i_cfg_index,
    input  logic [CFG_DATA_W-1:0]  i_cfg_data,
    output logic                   o_rom_rd,
    output logic [SINE_ADDR_W-1:0] o_rom_addr,
    input  logic [SINE_W-1:0]      i_rom_data
);

    localparam int DIV_W = FREQ_W + PHASE_BITS;
    localparam int CNT_W = $clog2(DIV_W + 1);

    t_in_item               r_item;
    logic [RATE_W-1:0]      r_rate;
    logic [VOL_W-1:0]       r_vol;
    logic [PHASE_BITS-1:0]  r_phase_acc;
    logic [PHASE_BITS-1:0]  r_phase_step;
    logic [LEFT_W-1:0]      r_left;
    logic                   r_silence;
    logic [PROD_W-1:0]      r_prod;
    logic [DIV_W-1:0]       r_dvd;
    logic [DIV_W-1:0]       r_quo;
    logic [RATE_W-1:0]      r_dvs;
    logic [RATE_W-1:0]      r_rem;
    logic [CNT_W-1:0]       r_cnt;
    logic                   r_neg;
    logic                   r_peak;
    logic                   r_last;
    logic                   r_out_valid;
    t_out_item              r_out;

    logic                     w_in_accept;
    logic                     w_out_full;
    logic                     w_emit;
    logic [SINE_ADDR_W+1:0]   w_pidx;
    logic [1:0]               w_quad;
    logic [SINE_ADDR_W-1:0]   w_idx;
    logic [SINE_ADDR_W-1:0]   w_idx_neg;
    logic [RATE_W-1:0]        w_mul_a;
    logic [DUR_W-1:0]         w_mul_b;
    logic [PROD_W-1:0]        w_prod;
    logic [MS_SCALED_W-1:0]   w_scaled;
    logic [MS_RPROD_W-1:0]    w_recip;
    logic [RATE_W:0]          w_rem_sh;
    logic [RATE_W:0]          w_diff;
    logic                     w_ge;
    logic                     w_count_over;
    logic [LEFT_W-1:0]        w_count;
    logic [VOL_W-1:0]         w_mag;
    logic signed [SAMPLE_W-1:0] w_sample;

    assign w_in_accept = i_in_valid & i_ctrl.in_ready;
    assign w_out_full  = r_out_valid & ~i_out_ready;
    assign w_emit      = (i_ctrl.dp == DP_EMIT) & ~w_out_full;

    always_comb begin
        o_status.no_req    = ~w_in_accept;
        o_status.op_load   = (r_item.op == OP_LOAD);
        o_status.left_zero = (r_left == '0);
        o_status.out_full  = w_out_full;
        o_status.div_more  = (r_cnt != CNT_W'(1));
    end

    // table address: top phase bits, mirrored in odd quadrants
    assign w_pidx     = r_phase_acc[PHASE_BITS-1 -: SINE_ADDR_W+2];
    assign w_quad     = w_pidx[SINE_ADDR_W+1:SINE_ADDR_W];
    assign w_idx      = w_pidx[SINE_ADDR_W-1:0];
    assign w_idx_neg  = ~w_idx + SINE_ADDR_W'(1);
    assign o_rom_addr = w_quad[0] ? w_idx_neg : w_idx;
    assign o_rom_rd   = (i_ctrl.dp == DP_TICK_RD);

    // shared multiplier: amplitude times volume, or rate times duration
    always_comb begin
        if (i_ctrl.dp == DP_MUL_VOL) begin
            if (r_silence) begin
                w_mul_a = '0;
            end else if (r_peak) begin
                w_mul_a = RATE_W'(SINE_PEAK);
            end else begin
                w_mul_a = RATE_W'(i_rom_data);
            end
            w_mul_b = DUR_W'(r_vol);
        end else begin
            w_mul_a = r_rate;
            w_mul_b = r_item.length_ms;
        end
    end
    assign w_prod = PROD_W'(w_mul_a) * PROD_W'(w_mul_b);

    // sample count: divide by 8 with a shift, then by 125 with a reciprocal multiply
    assign w_scaled = r_prod[PROD_W-1:MS_PRE_SHIFT];
    assign w_recip  = MS_RPROD_W'(w_scaled) * MS_RPROD_W'(MS_RECIP);

    // one restoring division step per cycle
    assign w_rem_sh = {r_rem, r_dvd[DIV_W-1]};
    assign w_ge     = (w_rem_sh >= {1'b0, r_dvs});
    assign w_diff   = w_rem_sh - {1'b0, r_dvs};

    assign w_count_over = |r_quo[DIV_W-1:LEFT_W];
    assign w_count      = w_count_over ? {LEFT_W{1'b1}} : r_quo[LEFT_W-1:0];

    assign w_mag    = r_prod[VOL_W+SINE_W-1:VOL_W];
    assign w_sample = r_neg ? -$signed({1'b0, w_mag}) : $signed({1'b0, w_mag});

    // payload registers
    always_ff @(posedge i_clk) begin
        if (w_in_accept) begin
            r_item <= i_in_data;
        end
        if (w_emit) begin
            r_out.sample <= w_sample;
            r_out.last   <= r_last;
        end
        case (i_ctrl.dp) inside
            DP_MUL_VOL, DP_MUL_CNT: begin
                r_prod <= w_prod;
            end
            DP_MUL_RECIP: begin
                r_quo <= DIV_W'(w_recip[MS_RPROD_W-1:MS_RECIP_SHIFT]);
            end
            DP_DIV_STEP: begin
                r_dvd <= r_dvd << 1;
                r_rem <= w_ge ? w_diff[RATE_W-1:0] : w_rem_sh[RATE_W-1:0];
                r_quo <= {r_quo[DIV_W-2:0], w_ge};
            end
            DP_SET_CNT: begin
                r_dvd <= DIV_W'({r_item.freq_hz, {PHASE_BITS{1'b0}}});
                r_dvs <= r_rate;
                r_rem <= '0;
                r_quo <= '0;
            end
            DP_TICK_RD: begin
                r_neg  <= w_quad[1];
                r_peak <= w_quad[0] & (w_idx == '0);
                r_last <= (r_left == LEFT_W'(1));
            end
            default: ;
        endcase
    end

    // control and architectural state
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_rate       <= RATE_RESET;
            r_vol        <= VOLUME_RESET;
            r_phase_acc  <= '0;
            r_phase_step <= '0;
            r_left       <= '0;
            r_silence    <= 1'b0;
            r_cnt        <= '0;
            r_out_valid  <= 1'b0;
        end else begin
            if (i_cfg_valid) begin
                case (i_cfg_index)
                    REG_SAMPLE_RATE: r_rate <= i_cfg_data;
                    REG_VOLUME:      r_vol  <= i_cfg_data[VOL_W-1:0];
                    default: ;
                endcase
            end
            if (w_emit) begin
                r_out_valid <= 1'b1;
            end else if (i_out_ready) begin
                r_out_valid <= 1'b0;
            end
            case (i_ctrl.dp) inside
                DP_DIV_STEP: begin
                    r_cnt <= r_cnt - CNT_W'(1);
                end
                DP_SET_CNT: begin
                    r_cnt  <= CNT_W'(DIV_W);
                    r_left <= w_count;
                end
                DP_SET_STEP: begin
                    r_phase_step <= (r_rate == '0) ? '0 : r_quo[PHASE_BITS-1:0];
                    r_phase_acc  <= '0;
                    r_silence    <= r_item.silent;
                end
                DP_TICK_RD: begin
                    r_phase_acc <= r_phase_acc + r_phase_step;
                    r_left      <= r_left - LEFT_W'(1);
                end
                default: ;
            endcase
        end
    end

    assign o_out_valid = r_out_valid;
    assign o_out_data  = r_out;

endmodule

>>> hdl/stg_checker.sv
// port level checks of the sine tone generator and their bind
module stg_checker
    import stg_pkg::*;
(
    input logic      i_clk,
    input logic      i_rst_n,
    input logic      i_in_valid,
    input logic      o_in_ready,
    input t_in_item  i_in_data,
    input logic      o_out_valid,
    input logic      i_out_ready,
    input t_out_item o_out_data
);

    // no sample pending straight after reset
    a_rst_clear: assert property (@(posedge i_clk) !i_rst_n |=> !o_out_valid)
        else $error("sample valid after reset");

    // a stalled sample stays offered
    a_out_hold: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (o_out_valid && !i_out_ready) |=> o_out_valid)
        else $error("sample dropped while stalled");

    // a stalled sample keeps its value
    a_out_stable: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (o_out_valid && !i_out_ready) |=> $stable(o_out_data))
        else $error("sample changed while stalled");

    // one request at a time: busy right after an acceptance
    a_busy: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (i_in_valid && o_in_ready) |=> !o_in_ready)
        else $error("request taken while busy");

    // a load never produces a sample
    a_load_quiet: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (i_in_valid && o_in_ready && i_in_data.op == OP_LOAD && !o_out_valid)
        |=> !o_out_valid)
        else $error("sample after load request");

endmodule

bind sine_tone_generator stg_checker u_stg_checker (
    .i_clk       (i_clk),
    .i_rst_n     (i_rst_n),
    .i_in_valid  (i_in_valid),
    .o_in_ready  (o_in_ready),
    .i_in_data   (i_in_data),
    .o_out_valid (o_out_valid),
    .i_out_ready (i_out_ready),
    .o_out_data  (o_out_data)
);

>>> sim/testbench.sv
// self-checking testbench for the sine tone generator: directed and random requests
`timescale 1ns / 100ps

module testbench;
    import stg_pkg::*;

    // a load keeps the sequencer busy for one divider run plus a few control steps
    localparam int LOAD_CYCLES = (16 + STG_PHASE_BITS) + 6;
    localparam int PHASE_W     = STG_PHASE_BITS;
    localparam int LOOKUP_W    = SINE_ADDR_W + 2;
    localparam logic [LEFT_W-1:0] LEFT_MAX = '1;
    localparam logic [SINE_W-1:0] QUARTER_PEAK = '1;

    // spare register indexes, the block must ignore writes to them
    localparam logic [CFG_IDX_W-1:0] REG_SPARE_A = 2'd2;
    localparam logic [CFG_IDX_W-1:0] REG_SPARE_B = 2'd3;

    logic                  i_clk = 1'b0;
    logic                  i_rst_n = 1'b0;
    logic                  i_in_valid = 1'b0;
    logic                  o_in_ready;
    t_in_item              i_in_data = '0;
    logic                  o_out_valid;
    logic                  i_out_ready = 1'b1;
    t_out_item             o_out_data;
    logic                  i_cfg_valid = 1'b0;
    logic                  o_cfg_ready;
    logic [CFG_IDX_W-1:0]  i_cfg_index = '0;
    logic [CFG_DATA_W-1:0] i_cfg_data = '0;

    sine_tone_generator u_dut (
        .i_clk       (i_clk),
        .i_rst_n     (i_rst_n),
        .i_in_valid  (i_in_valid),
        .o_in_ready  (o_in_ready),
        .i_in_data   (i_in_data),
        .o_out_valid (o_out_valid),
        .i_out_ready (i_out_ready),
        .o_out_data  (o_out_data),
        .i_cfg_valid (i_cfg_valid),
        .o_cfg_ready (o_cfg_ready),
        .i_cfg_index (i_cfg_index),
        .i_cfg_data  (i_cfg_data)
    );

    // predicted tone state, kept in step with every accepted request
    logic [RATE_W-1:0]  cfg_rate;
    logic [VOL_W-1:0]   cfg_volume;
    logic [PHASE_W-1:0] tone_phase;
    logic [PHASE_W-1:0] tone_increment;
    logic [LEFT_W-1:0]  tone_left;
    logic               tone_silent;
    logic [SINE_W-1:0]  quarter_wave [SINE_DEPTH];

    t_out_item expected_samples [$];

    // when set, neither side inserts idle cycles
    bit steady = 1'b0;

    int error_count   = 0;
    int n_loads       = 0;
    int n_ticks       = 0;
    int n_checked     = 0;
    int n_writes      = 0;

    // clock, 4 ns period
    initial begin
        forever #2 i_clk = ~i_clk;
    end

    // watchdog: far beyond the slowest legal run
    initial begin
        #4000000;
        $display("Simulation FAILED");
        $finish;
    end

    // quarter wave entry k: taylor series of the angle in q30, rounded to q15
    function automatic logic [SINE_W-1:0] quarter_wave_entry(input int unsigned k);
        logic [63:0]        x;
        logic [63:0]        x2;
        logic [63:0]        term;
        logic [63:0]        v;
        logic signed [63:0] acc;
        int                 n;
        x    = (HALF_PI_Q30 * 64'(k)) / 64'(SINE_DEPTH);
        x2   = (x * x) >> 30;
        term = x;
        acc  = $signed(x);
        for (n = 1; n <= 5; n++) begin
            term = ((term * x2) >> 30) / 64'((2 * n) * (2 * n + 1));
            // odd powers alternate in sign
            if (n % 2 == 1) begin
                acc = acc - $signed(term);
            end else begin
                acc = acc + $signed(term);
            end
        end
        if (acc < 0) begin
            acc = 0;
        end
        v = (64'(acc) * 64'd32767 + (64'd1 << 29)) >> 30;
        if (v > 64'd32767) begin
            v = 64'd32767;
        end
        return v[SINE_W-1:0];
    endfunction

    // applies one request to the predicted state; returns 1 when a sample results
    function automatic bit tone_apply(input t_in_item req, output t_out_item smp);
        logic [63:0]         count;
        logic [63:0]         numer;
        logic [63:0]         quot;
        logic [LOOKUP_W-1:0] slot;
        logic [SINE_W-1:0]   unit;
        logic [31:0]         mag;
        logic [15:0]         mag16;
        smp = '0;
        if (req.op == OP_LOAD) begin
            // sample count saturates at the width of the down counter
            count = (64'(cfg_rate) * 64'(req.length_ms)) / 64'd1000;
            tone_left = (count > 64'(LEFT_MAX)) ? LEFT_MAX : count[LEFT_W-1:0];
            tone_phase = '0;
            // increment wraps when the tone is at or above the sample rate
            numer = 64'(req.freq_hz) << PHASE_W;
            quot  = (cfg_rate == '0) ? 64'd0 : numer / 64'(cfg_rate);
            tone_increment = quot[PHASE_W-1:0];
            tone_silent = req.silent;
            return 1'b0;
        end
        // tick with nothing left to play
        if (tone_left == '0) begin
            return 1'b0;
        end
        if (tone_silent) begin
            smp.sample = '0;
        end else begin
            slot = tone_phase[PHASE_W-1 -: LOOKUP_W];
            // odd quadrants read the table backwards, the peak sits past its end
            if (!slot[SINE_ADDR_W]) begin
                unit = quarter_wave[slot[SINE_ADDR_W-1:0]];
            end else if (slot[SINE_ADDR_W-1:0] == '0) begin
                unit = QUARTER_PEAK;
            end else begin
                unit = quarter_wave[SINE_DEPTH - int'(slot[SINE_ADDR_W-1:0])];
            end
            mag   = (32'(unit) * 32'(cfg_volume)) >> 15;
            mag16 = mag[15:0];
            // lower half wave: negate the truncated magnitude
            smp.sample = slot[SINE_ADDR_W+1] ? 16'(-mag16) : mag16;
        end
        tone_phase = tone_phase + tone_increment;
        tone_left  = tone_left - 1'b1;
        smp.last   = (tone_left == '0);
        return 1'b1;
    endfunction

    function automatic t_in_item make_request(input logic op, input logic [FREQ_W-1:0] freq,
                                              input logic [DUR_W-1:0] dur, input logic mute);
        t_in_item req;
        req.op        = op;
        req.freq_hz   = freq;
        req.length_ms = dur;
        req.silent    = mute;
        return req;
    endfunction

    // one request through the handshake, then into the predictor
    task automatic send_request(input t_in_item req);
        int        gap;
        t_out_item smp;
        gap = steady ? 0 : $urandom_range(0, 4);
        if (gap > 0) begin
            i_in_valid <= 1'b0;
            repeat (gap) @(posedge i_clk);
        end
        i_in_valid <= 1'b1;
        i_in_data  <= req;
        do @(posedge i_clk); while (!o_in_ready);
        if (req.op == OP_LOAD) begin
            n_loads++;
        end else begin
            n_ticks++;
        end
        if (tone_apply(req, smp)) begin
            expected_samples.push_back(smp);
        end
    endtask

    task automatic send_tick();
        send_request(make_request(OP_TICK, 16'($urandom), 16'($urandom),
                                  1'($urandom_range(0, 1))));
    endtask

    // stop sending, let every expected sample arrive and any load finish
    task automatic settle_idle();
        i_in_valid <= 1'b0;
        @(posedge i_clk);
        while (expected_samples.size() != 0) @(posedge i_clk);
        repeat (LOAD_CYCLES + 8) @(posedge i_clk);
    endtask

    task automatic write_register(input logic [CFG_IDX_W-1:0] idx,
                                  input logic [CFG_DATA_W-1:0] value);
        settle_idle();
        i_cfg_valid <= 1'b1;
        i_cfg_index <= idx;
        i_cfg_data  <= value;
        do @(posedge i_clk); while (!o_cfg_ready);
        i_cfg_valid <= 1'b0;
        // volume keeps only its low bits, spare indexes change nothing
        if (idx == REG_SAMPLE_RATE) begin
            cfg_rate = value;
        end else if (idx == REG_VOLUME) begin
            cfg_volume = value[VOL_W-1:0];
        end
        n_writes++;
    endtask

    // sample sink: random back-pressure, after a sample and now and then while idle
    initial begin : sample_sink
        int stall;
        forever begin
            @(posedge i_clk);
            stall = 0;
            if (!steady) begin
                if (o_out_valid && i_out_ready) begin
                    stall = $urandom_range(0, 4);
                end else if ($urandom_range(0, 7) == 0) begin
                    stall = $urandom_range(1, 4);
                end
            end
            if (stall > 0) begin
                i_out_ready <= 1'b0;
                repeat (stall) @(posedge i_clk);
                i_out_ready <= 1'b1;
            end
        end
    end

    // every accepted sample against the oldest prediction
    always @(posedge i_clk) begin : sample_check
        t_out_item want;
        if (i_rst_n && o_out_valid && i_out_ready) begin
            if (expected_samples.size() == 0) begin
                $error("unexpected sample %0d last %0b", o_out_data.sample, o_out_data.last);
                error_count++;
            end else begin
                want = expected_samples.pop_front();
                if (o_out_data.sample !== want.sample) begin
                    $error("sample: expected %0d, got %0d", want.sample, o_out_data.sample);
                    error_count++;
                end
                if (o_out_data.last !== want.last) begin
                    $error("last: expected %0b, got %0b", want.last, o_out_data.last);
                    error_count++;
                end
                n_checked++;
            end
        end
    end

    // reset defaults: idle tick, a long silence cut short, a tone stepping a quarter turn
    task automatic test_idle_and_silence();
        int k;
        send_tick();
        send_request(make_request(OP_LOAD, 16'hFFFF, 16'hFFFF, 1'b1));
        send_tick();
        send_tick();
        // 4 kHz at 16 kHz: phase visits zero, peak, zero and trough; 16 samples
        send_request(make_request(OP_LOAD, 16'd4000, 16'd1, 1'b0));
        for (k = 0; k < 17; k++) begin
            send_tick();
        end
    endtask

    // register extremes: saturating count, replaced tone, zero rate, spare indexes
    task automatic test_register_extremes();
        write_register(REG_SAMPLE_RATE, '1);
        // upper data bits beyond the volume width must be dropped
        write_register(REG_VOLUME, '1);
        write_register(REG_SPARE_A, 17'h00123);
        write_register(REG_SPARE_B, 17'h1FFFF);
        send_request(make_request(OP_LOAD, 16'hFFFF, 16'hFFFF, 1'b0));
        send_tick();
        send_tick();
        send_request(make_request(OP_LOAD, 16'd0, 16'd0, 1'b0));
        send_tick();
        write_register(REG_SAMPLE_RATE, '0);
        write_register(REG_VOLUME, '0);
        send_request(make_request(OP_LOAD, 16'd1234, 16'd500, 1'b0));
        send_tick();
    endtask

    // random tones under one register setting until enough requests did real work
    task automatic run_random_phase(input int unsigned target);
        int unsigned done_items;
        int unsigned dur_max;
        int unsigned count;
        int unsigned ticks;
        int unsigned kind;
        int unsigned k;
        done_items = 0;
        while (done_items < target) begin
            kind = $urandom_range(0, 19);
            if (kind < 17) begin
                // well formed: short tone, then ticks to its end or cut short by the next load
                dur_max = (cfg_rate == '0) ? 65535 : 48000 / int'(cfg_rate);
                if (dur_max == 0) begin
                    dur_max = 1;
                end else if (dur_max > 65535) begin
                    dur_max = 65535;
                end
                send_request(make_request(OP_LOAD, 16'($urandom),
                                          16'($urandom_range(0, dur_max)),
                                          $urandom_range(0, 4) == 0));
                count = tone_left;
                ticks = (kind < 12) ? count + $urandom_range(0, 2) : $urandom_range(0, count);
            end else if (kind < 19) begin
                // noise: any duration, few ticks before being replaced
                send_request(make_request(OP_LOAD, 16'($urandom), 16'($urandom),
                                          1'($urandom_range(0, 1))));
                count = tone_left;
                ticks = $urandom_range(0, 6);
            end else begin
                // stray ticks, mostly after the tone has run out
                count = 0;
                ticks = $urandom_range(1, 3);
            end
            for (k = 0; k < ticks; k++) begin
                send_tick();
            end
            done_items += ((kind < 19) ? 1 : 0) + ((ticks < count) ? ticks : count);
        end
    endtask

    task automatic test_random_traffic();
        int                phase;
        logic [RATE_W-1:0] rate;
        logic [VOL_W-1:0]  vol;
        for (phase = 0; phase < 12; phase++) begin
            vol = VOL_W'($urandom_range(0, 32767));
            case (phase)
                0: begin
                    rate = RATE_W'(8000);
                    vol  = '1;
                end
                1: begin
                    rate = RATE_W'(96000);
                    vol  = '0;
                end
                2: rate = RATE_W'(44100);
                3: rate = '1;
                4: begin
                    rate = RATE_W'(1);
                    vol  = VOL_W'(1);
                end
                5: rate = '0;
                6: begin
                    rate = RATE_RESET;
                    vol  = VOLUME_RESET;
                end
                default: rate = RATE_W'($urandom_range(8000, 96000));
            endcase
            write_register(REG_SAMPLE_RATE, rate);
            write_register(REG_VOLUME, CFG_DATA_W'(vol));
            // every fourth setting runs with no idle cycles on either side
            steady = (phase % 4 == 2);
            // a zero rate never plays, so only a short run of loads
            run_random_phase((phase == 5) ? 30 : 150);
            steady = 1'b0;
        end
    endtask

    initial begin : main_sequence
        int k;
        for (k = 0; k < SINE_DEPTH; k++) begin
            quarter_wave[k] = quarter_wave_entry(k);
        end
        cfg_rate       = RATE_RESET;
        cfg_volume     = VOLUME_RESET;
        tone_phase     = '0;
        tone_increment = '0;
        tone_left      = '0;
        tone_silent    = 1'b0;

        repeat (10) @(posedge i_clk);
        i_rst_n <= 1'b1;
        @(posedge i_clk);

        test_idle_and_silence();
        test_register_extremes();
        test_random_traffic();

        settle_idle();
        $display("covered %0d loads and %0d ticks over %0d register writes", n_loads, n_ticks,
                 n_writes);
        $display("checked %0d samples with random gaps and back-pressure", n_checked);
        if (error_count == 0 && expected_samples.size() == 0) begin
            $display("Simulation PASSED");
        end else begin
            $display("Simulation FAILED");
        end
        $finish;
    end

endmodule
